### rtl/mpd_pkg.sv
// Package for the multi-tap ping-pong delay: sizes, register codes, sequencer states,
// tap tables and the saturation helper. No dependencies.
package mpd_pkg;

	localparam int STORE_DEPTH = 65536;
	localparam int SAMPLE_W    = 24;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int POS_W       = ADDR_W + 8;
	localparam int SUM_W       = 50;
	localparam int WET_W       = SUM_W - 24;
	localparam int GLIDE_W     = 40;
	localparam int MAC_A_W     = 34;
	localparam int MAC_B_W     = 20;
	localparam int ACC_W       = 64;

	// Register indexes.
	localparam logic [1:0] REG_MIX    = 2'd0;
	localparam logic [1:0] REG_GAIN   = 2'd1;
	localparam logic [1:0] REG_DELAY  = 2'd2;
	localparam logic [1:0] REG_SPREAD = 2'd3;

	// Glide channel select.
	localparam logic [1:0] GL_MIX = 2'd0;
	localparam logic [1:0] GL_DLY = 2'd1;
	localparam logic [1:0] GL_SPR = 2'd2;

	localparam logic [16:0] MIX_MAX    = 17'd65536;
	localparam logic [15:0] GAIN_MAX   = 16'd64225;
	localparam logic [23:0] DELAY_MIN  = 24'd256;
	localparam logic [18:0] SPREAD_MAX = 19'd512000;
	localparam logic [16:0] MIX_RST    = 17'd32768;
	localparam logic [15:0] GAIN_RST   = 16'd32768;
	localparam logic [23:0] DELAY_RST  = 24'd12288000;
	localparam logic [18:0] SPREAD_RST = 19'd1280;

	// 0.0001 in Q0.32.
	localparam logic signed [MAC_B_W-1:0] GLIDE_COEF = 20'sd429497;

	localparam logic signed [MAC_B_W-1:0] TAP_WEIGHT [4] =
		'{20'sd19661, 20'sd39322, -20'sd13107, 20'sd6554};
	localparam logic signed [MAC_B_W-1:0] TAP_MULT [4] =
		'{20'sd0, 20'sd2, 20'sd7, 20'sd11};

	localparam logic signed [ACC_W-1:0] S_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
	localparam logic signed [ACC_W-1:0] S_MIN = -(64'sd1 <<< (SAMPLE_W - 1));

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_GLO, S_GHI, S_GWAIT, S_GUPD, S_WRITE,
		S_TPOS, S_TWAIT, S_TADDR, S_TRDA, S_TRDB,
		S_IL0, S_IL1, S_IR0, S_IR1, S_WL, S_WR, S_WWL, S_WWR,
		S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7
	} state_t;

	// One operation for the shared multiply-accumulate unit.
	typedef struct packed {
		logic                       issue;
		logic                       start;
		logic                       shift;
		logic signed [MAC_A_W-1:0]  a;
		logic signed [MAC_B_W-1:0]  b;
		logic signed [ACC_W-1:0]    bias;
	} mac_op_t;

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > S_MAX) r = S_MAX[SAMPLE_W-1:0];
		else if (v < S_MIN) r = S_MIN[SAMPLE_W-1:0];
		else r = v[SAMPLE_W-1:0];
		return r;
	endfunction

endpackage

### rtl/mpd_mac.sv
// Shared multiply-accumulate unit: one registered product stage, then the accumulator.
// Depends on mpd_pkg.
module mpd_mac (
	input  logic             clk,
	input  logic             arst_n,
	input  mpd_pkg::mac_op_t op,
	output logic signed [mpd_pkg::ACC_W-1:0] acc
);
	import mpd_pkg::*;

	localparam int PROD_W = MAC_A_W + MAC_B_W;

	logic                     valid_s1;
	logic                     start_s1;
	logic                     shift_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  bias_s1;
	logic signed [ACC_W-1:0]  prod_x;
	logic signed [ACC_W-1:0]  acc_q;

	// Product stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= op.issue;
		end
	end

	always_ff @(posedge clk) begin
		start_s1 <= op.start;
		shift_s1 <= op.shift;
		prod_s1  <= op.a * op.b;
		bias_s1  <= op.bias;
	end

	assign prod_x = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};

	// Accumulate stage; a start loads the bias instead of the running sum.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_q <= (start_s1 ? bias_s1 : acc_q) + (shift_s1 ? (prod_x <<< 24) : prod_x);
		end
	end

	assign acc = acc_q;
endmodule

### rtl/mpd_ram.sv
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module mpd_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/multitap_pingpong_delay_top.sv
// Top level of the multi-tap ping-pong delay: sequencer, datapath registers, two sample stores.
// Depends on mpd_pkg, mpd_mac and mpd_ram.
//
// Usage: one input beat carries a stereo pair (left_in, right_in); one output beat carries the
// mixed pair (left_out, right_out). Both channels use valid/stall; a beat moves on a clock edge
// with valid high and stall low. Registers are written through cfg_wr_en/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block itself does not
// enforce. Out-of-range values are clamped. Each pair runs through a sequencer around one
// shared multiply-accumulate unit: three control glides, the crossed store write, four taps
// (position, two store reads, interpolation and weighting) and feedback plus output mix.
// in_stall is high from acceptance until the sequencer returns to idle, so pairs are processed
// one at a time: they share the multiply-accumulate unit and the single read port of each store.
// After reset the stores are cleared one entry per cycle; in_stall stays high until all are done.
// A finished pair waits in the output register; a new input beat is taken while it waits, and
// the sequencer holds its next result until the receiver drops out_stall.
module multitap_pingpong_delay_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [mpd_pkg::SAMPLE_W-1:0] left_in,
	input  logic signed [mpd_pkg::SAMPLE_W-1:0] right_in,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [mpd_pkg::SAMPLE_W-1:0] left_out,
	output logic signed [mpd_pkg::SAMPLE_W-1:0] right_out,
	input  logic cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [23:0] cfg_data
);
	import mpd_pkg::*;

	state_t state_q, state_d;

	logic [16:0] mix_q;
	logic [15:0] gain_q;
	logic [23:0] dly_q;
	logic [18:0] spr_q;
	logic [32:0] smix_q;
	logic [39:0] sdly_q;
	logic [34:0] sspr_q;

	logic [1:0]        g_q;
	logic [1:0]        k_q;
	logic [ADDR_W-1:0] wp_q;
	logic [ADDR_W-1:0] clr_q;

	logic signed [SAMPLE_W-1:0] dry_l_q, dry_r_q, lfb_q, rfb_q;
	logic signed [SAMPLE_W-1:0] a_l_q, a_r_q, b_l_q, b_r_q;
	logic signed [SAMPLE_W-1:0] res_l_q;
	logic signed [SAMPLE_W-1:0] left_out_q, right_out_q;
	logic                       out_valid_q;
	logic [POS_W-1:0]           pos_q;
	logic signed [MAC_A_W-1:0]  tap_l_q;
	logic signed [SUM_W-1:0]    sum_l_q, sum_r_q;

	mac_op_t                 mac_op;
	logic signed [ACC_W-1:0] acc;

	logic [GLIDE_W-1:0] cur_g, tgt_g, gdist, glided;
	logic               up;
	logic [27:0]        step;
	logic [16:0]        mix_u, inv_mix;
	logic [23:0]        dly_u;
	logic [18:0]        spr_u;
	logic [POS_W-1:0]   base;
	logic [7:0]         frac;
	logic [8:0]         frac_inv;
	logic signed [SUM_W-1:0] rnd_l, rnd_r;
	logic signed [WET_W-1:0] wet_l, wet_r;
	logic               accept, out_free;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [SAMPLE_W-1:0] wdata_l, wdata_r, rdata_l, rdata_r;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Values in use and derived operands.
	assign mix_u    = smix_q[32:16];
	assign dly_u    = sdly_q[39:16];
	assign spr_u    = sspr_q[34:16];
	assign inv_mix  = 17'(18'd65536 - {1'b0, mix_u});
	assign base     = {wp_q, 8'h00} - POS_W'(dly_u);
	assign frac     = pos_q[7:0];
	assign frac_inv = 9'd256 - {1'b0, frac};
	assign rnd_l    = sum_l_q + SUM_W'(64'sd1 <<< 23);
	assign rnd_r    = sum_r_q + SUM_W'(64'sd1 <<< 23);
	assign wet_l    = rnd_l[SUM_W-1:24];
	assign wet_r    = rnd_r[SUM_W-1:24];

	// Glide distance and next value for the selected control.
	always_comb begin
		case (g_q)
			GL_MIX: begin
				cur_g = {7'b0, smix_q};
				tgt_g = {7'b0, mix_q, 16'b0};
			end
			GL_DLY: begin
				cur_g = sdly_q;
				tgt_g = {dly_q, 16'b0};
			end
			default: begin
				cur_g = {5'b0, sspr_q};
				tgt_g = {5'b0, spr_q, 16'b0};
			end
		endcase
		up     = (tgt_g >= cur_g);
		gdist  = up ? (tgt_g - cur_g) : (cur_g - tgt_g);
		step   = acc[59:32];
		glided = up ? (cur_g + GLIDE_W'(step)) : (cur_g - GLIDE_W'(step));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == ADDR_W'(STORE_DEPTH - 1)) state_d = S_IDLE;
			S_IDLE:  if (in_valid) state_d = S_GLO;
			S_GLO:   state_d = S_GHI;
			S_GHI:   state_d = S_GWAIT;
			S_GWAIT: state_d = S_GUPD;
			S_GUPD:  state_d = (g_q == GL_SPR) ? S_WRITE : S_GLO;
			S_WRITE: state_d = S_TPOS;
			S_TPOS:  state_d = S_TWAIT;
			S_TWAIT: state_d = S_TADDR;
			S_TADDR: state_d = S_TRDA;
			S_TRDA:  state_d = S_TRDB;
			S_TRDB:  state_d = S_IL0;
			S_IL0:   state_d = S_IL1;
			S_IL1:   state_d = S_IR0;
			S_IR0:   state_d = S_IR1;
			S_IR1:   state_d = S_WL;
			S_WL:    state_d = S_WR;
			S_WR:    state_d = S_WWL;
			S_WWL:   state_d = S_WWR;
			S_WWR:   state_d = (k_q == 2'd3) ? S_F0 : S_TPOS;
			S_F0:    state_d = S_F1;
			S_F1:    state_d = S_F2;
			S_F2:    state_d = S_F3;
			S_F3:    state_d = S_F4;
			S_F4:    state_d = S_F5;
			S_F5:    state_d = S_F6;
			S_F6:    state_d = S_F7;
			S_F7:    if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: operations for the shared unit and store access.
	always_comb begin
		mac_op    = '0;
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		wdata_l   = sat_sample(ACC_W'(dry_r_q) + ACC_W'(rfb_q));
		wdata_r   = sat_sample(ACC_W'(dry_l_q) + ACC_W'(lfb_q));
		ram_raddr = pos_q[POS_W-1:8] + ADDR_W'(1);
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				wdata_l   = '0;
				wdata_r   = '0;
			end
			S_WRITE: ram_we = 1'b1;
			S_GLO: begin
				mac_op.issue = 1'b1;
				mac_op.start = 1'b1;
				mac_op.a     = {10'b0, gdist[23:0]};
				mac_op.b     = GLIDE_COEF;
				mac_op.bias  = 64'sh8000_0000;
			end
			S_GHI: begin
				mac_op.issue = 1'b1;
				mac_op.shift = 1'b1;
				mac_op.a     = {18'b0, gdist[39:24]};
				mac_op.b     = GLIDE_COEF;
			end
			S_TPOS: begin
				mac_op.issue = 1'b1;
				mac_op.start = 1'b1;
				mac_op.a     = {15'b0, spr_u};
				mac_op.b     = TAP_MULT[k_q];
				mac_op.bias  = {{(ACC_W-POS_W){1'b0}}, base};
			end
			S_TADDR: ram_raddr = acc[POS_W-1:8];
			S_IL0: begin
				mac_op.issue = 1'b1;
				mac_op.start = 1'b1;
				mac_op.a     = MAC_A_W'(a_l_q);
				mac_op.b     = {11'b0, frac_inv};
			end
			S_IL1: begin
				mac_op.issue = 1'b1;
				mac_op.a     = MAC_A_W'(b_l_q);
				mac_op.b     = {12'b0, frac};
			end
			S_IR0: begin
				mac_op.issue = 1'b1;
				mac_op.start = 1'b1;
				mac_op.a     = MAC_A_W'(a_r_q);
				mac_op.b     = {11'b0, frac_inv};
			end
			S_IR1: begin
				mac_op.issue = 1'b1;
				mac_op.a     = MAC_A_W'(b_r_q);
				mac_op.b     = {12'b0, frac};
			end
			S_WL: begin
				mac_op.issue = 1'b1;
				mac_op.start = 1'b1;
				mac_op.a     = tap_l_q;
				mac_op.b     = TAP_WEIGHT[k_q];
				mac_op.bias  = ACC_W'(sum_l_q);
			end
			S_WR: begin
				mac_op.issue = 1'b1;
				mac_op.start = 1'b1;
				mac_op.a     = acc[MAC_A_W-1:0];
				mac_op.b     = TAP_WEIGHT[k_q];
				mac_op.bias  = ACC_W'(sum_r_q);
			end
			S_F0, S_F1: begin
				mac_op.issue = 1'b1;
				mac_op.start = 1'b1;
				mac_op.a     = (state_q == S_F0) ? MAC_A_W'(wet_l) : MAC_A_W'(wet_r);
				mac_op.b     = {4'b0, gain_q};
				mac_op.bias  = 64'sd32768;
			end
			S_F2, S_F4: begin
				mac_op.issue = 1'b1;
				mac_op.start = 1'b1;
				mac_op.a     = (state_q == S_F2) ? MAC_A_W'(dry_l_q) : MAC_A_W'(dry_r_q);
				mac_op.b     = {3'b0, inv_mix};
				mac_op.bias  = 64'sd32768;
			end
			S_F3, S_F5: begin
				mac_op.issue = 1'b1;
				mac_op.a     = (state_q == S_F3) ? MAC_A_W'(wet_l) : MAC_A_W'(wet_r);
				mac_op.b     = {3'b0, mix_u};
			end
			default: ;
		endcase
	end

	mpd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.acc    (acc)
	);

	mpd_ram #(.DEPTH(STORE_DEPTH), .WIDTH(SAMPLE_W)) u_left_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wdata_l),
		.raddr (ram_raddr),
		.rdata (rdata_l)
	);

	mpd_ram #(.DEPTH(STORE_DEPTH), .WIDTH(SAMPLE_W)) u_right_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wdata_r),
		.raddr (ram_raddr),
		.rdata (rdata_r)
	);

	// Control state, counters, smoothed controls, feedback and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			g_q         <= GL_MIX;
			k_q         <= '0;
			wp_q        <= '0;
			lfb_q       <= '0;
			rfb_q       <= '0;
			out_valid_q <= 1'b0;
			mix_q       <= MIX_RST;
			gain_q      <= GAIN_RST;
			dly_q       <= DELAY_RST;
			spr_q       <= SPREAD_RST;
			smix_q      <= {MIX_RST, 16'b0};
			sdly_q      <= {DELAY_RST, 16'b0};
			sspr_q      <= {SPREAD_RST, 16'b0};
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (state_q == S_GUPD) begin
				case (g_q)
					GL_MIX:  smix_q <= glided[32:0];
					GL_DLY:  sdly_q <= glided;
					default: sspr_q <= glided[34:0];
				endcase
				g_q <= (g_q == GL_SPR) ? GL_MIX : g_q + 2'd1;
			end
			if (state_q == S_WWR) k_q <= k_q + 2'd1;
			if (state_q == S_F2) lfb_q <= sat_sample(acc >>> 16);
			if (state_q == S_F3) rfb_q <= sat_sample(acc >>> 16);
			if (state_q == S_F7 && out_free) begin
				out_valid_q <= 1'b1;
				wp_q        <= wp_q + ADDR_W'(1);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MIX:    mix_q  <= (cfg_data[16:0] > MIX_MAX) ? MIX_MAX : cfg_data[16:0];
					REG_GAIN:   gain_q <= (cfg_data[15:0] > GAIN_MAX) ? GAIN_MAX : cfg_data[15:0];
					REG_DELAY:  dly_q  <= (cfg_data < DELAY_MIN) ? DELAY_MIN : cfg_data;
					REG_SPREAD: spr_q  <= (cfg_data[18:0] > SPREAD_MAX) ?
					                      SPREAD_MAX : cfg_data[18:0];
					default: ;
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			dry_l_q <= left_in;
			dry_r_q <= right_in;
		end
		case (state_q)
			S_WRITE: begin
				sum_l_q <= '0;
				sum_r_q <= '0;
			end
			S_TADDR: pos_q <= acc[POS_W-1:0];
			S_TRDA: begin
				a_l_q <= rdata_l;
				a_r_q <= rdata_r;
			end
			S_TRDB: begin
				b_l_q <= rdata_l;
				b_r_q <= rdata_r;
			end
			S_IR1: tap_l_q <= acc[MAC_A_W-1:0];
			S_WWL: sum_l_q <= acc[SUM_W-1:0];
			S_WWR: sum_r_q <= acc[SUM_W-1:0];
			S_F5:  res_l_q <= sat_sample(acc >>> 16);
			S_F7: begin
				if (out_free) begin
					left_out_q  <= res_l_q;
					right_out_q <= sat_sample(acc >>> 16);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	// A new output beat appears only when the sequencer finishes an item.
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_F7))
		else $error("output beat without finished item");

	// An accepted input beat starts the control glide.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_GLO))
		else $error("accepted beat did not start processing");

	// The tap and glide counters have both wrapped by the time the output mix starts.
	a_tap_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_F0) |-> (k_q == 2'd0 && g_q == GL_MIX))
		else $error("tap or glide counter out of step");
endmodule
